// ===== rtl/index_to_sequence_unranker_assert.svh =====
`ifndef INDEX_TO_SEQUENCE_UNRANKER_ASSERT_SVH
`define INDEX_TO_SEQUENCE_UNRANKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ITSU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ITSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itsu_pkg.sv =====
package itsu_pkg;

	localparam int INDEX_WIDTH = 32;
	localparam int IDX_IN_W    = 32;
	localparam int ELEM_W      = 17;
	localparam int MAX_RESULTS = 7;

	localparam int SQ_W   = ((INDEX_WIDTH + 6) / 4) * 4;
	localparam int ROOT_W = SQ_W / 2;
	localparam int K_W    = ROOT_W - 1;
	localparam int ROUNDS = ROOT_W / 2;
	localparam int RND_W  = $clog2(ROUNDS + 1);
	localparam int CNT_W  = $clog2(MAX_RESULTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROOT,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic index_zero;
		logic root_done;
		logic last;
	} sts_t;

endpackage

// ===== rtl/itsu_dp.sv =====
module itsu_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itsu_pkg::cmd_t               cmd,
	output itsu_pkg::sts_t               sts,
	input  logic [itsu_pkg::IDX_IN_W-1:0] index,
	output logic [itsu_pkg::ELEM_W-1:0]  element,
	output logic                         last,
	output logic                         empty_res
);

	localparam int IW = itsu_pkg::INDEX_WIDTH;
	localparam int SW = itsu_pkg::SQ_W;
	localparam int RW = itsu_pkg::ROOT_W;
	localparam int KW = itsu_pkg::K_W;

	logic [IW-1:0]                  head_q;
	logic [SW-1:0]                  x_q;
	logic [RW-1:0]                  q_q;
	logic [RW+1:0]                  rem_q;
	logic [itsu_pkg::RND_W-1:0]     rnd_q;
	logic [itsu_pkg::CNT_W-1:0]     cnt_q;
	logic [itsu_pkg::ELEM_W-1:0]    elem_q;
	logic                           last_q;
	logic                           empty_q;

	logic [IW-1:0]   idx_w;
	logic [IW-1:0]   n_w;
	logic [RW+1:0]   rem1, trial1, rem_a, rem2, trial2, rem_b;
	logic            ge1, ge2;
	logic [RW-1:0]   q_a, q_b;
	logic            s_odd;
	logic [KW-1:0]   k_val;
	logic [RW+2:0]   rsum;
	logic [KW-1:0]   rest;
	logic [IW-1:0]   head_nxt;
	logic            fin_last;

	always_comb begin
		idx_w  = IW'(index);
		n_w    = head_q - IW'(1);

		rem1   = {rem_q[RW-1:0], x_q[SW-1 -: 2]};
		trial1 = {q_q, 2'b01};
		ge1    = rem1 >= trial1;
		rem_a  = ge1 ? rem1 - trial1 : rem1;
		q_a    = {q_q[RW-2:0], ge1};

		rem2   = {rem_a[RW-1:0], x_q[SW-3 -: 2]};
		trial2 = {q_a, 2'b01};
		ge2    = rem2 >= trial2;
		rem_b  = ge2 ? rem2 - trial2 : rem2;
		q_b    = {q_a[RW-2:0], ge2};

		s_odd  = q_q[0];
		k_val  = s_odd ? q_q[RW-1:1] : q_q[RW-1:1] - KW'(1);
		rsum   = (RW+3)'(rem_q);
		if (!s_odd) begin
			rsum = rsum + (RW+3)'({k_val, 2'b00}) + (RW+3)'(3);
		end
		rest     = rsum[KW+2:3];
		head_nxt = (rest <= k_val) ? IW'(k_val - rest) : '0;
		fin_last = (head_nxt == '0) ||
			(cnt_q == itsu_pkg::CNT_W'(itsu_pkg::MAX_RESULTS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.fin) begin
				cnt_q <= cnt_q + itsu_pkg::CNT_W'(1);
			end
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.step) begin
				rnd_q <= rnd_q + itsu_pkg::RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			head_q  <= idx_w;
			elem_q  <= '0;
			last_q  <= 1'b1;
			empty_q <= 1'b1;
		end
		if (cmd.start) begin
			x_q   <= SW'({n_w, 3'b001});
			q_q   <= '0;
			rem_q <= '0;
		end
		if (cmd.step) begin
			x_q   <= x_q << 4;
			q_q   <= q_b;
			rem_q <= rem_b;
		end
		if (cmd.fin) begin
			head_q  <= head_nxt;
			elem_q  <= itsu_pkg::ELEM_W'(rest);
			last_q  <= fin_last;
			empty_q <= 1'b0;
		end
	end

	assign sts.index_zero = (idx_w == '0);
	assign sts.root_done  = (rnd_q == itsu_pkg::RND_W'(itsu_pkg::ROUNDS));
	assign sts.last       = last_q;
	assign element        = elem_q;
	assign last           = last_q;
	assign empty_res      = empty_q;

`include "index_to_sequence_unranker_assert.svh"

	`ITSU_ASSERT_SAME(a_empty_alone, empty_q, last_q && (elem_q == '0), "empty beat not final")
	`ITSU_ASSERT_SAME(a_fin_after_root, cmd.fin, sts.root_done, "finish before root done")
	`ITSU_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= itsu_pkg::CNT_W'(itsu_pkg::MAX_RESULTS), "too many beats")

endmodule

// ===== rtl/itsu_ctrl.sv =====
module itsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  itsu_pkg::sts_t sts,
	output itsu_pkg::cmd_t cmd
);

	itsu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			itsu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.index_zero ? itsu_pkg::ST_EMIT : itsu_pkg::ST_START;
				end
			end
			itsu_pkg::ST_START: begin
				cmd.start = 1'b1;
				state_d   = itsu_pkg::ST_ROOT;
			end
			itsu_pkg::ST_ROOT: begin
				if (sts.root_done) begin
					state_d = itsu_pkg::ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			itsu_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = itsu_pkg::ST_EMIT;
			end
			itsu_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = sts.last ? itsu_pkg::ST_IDLE : itsu_pkg::ST_START;
				end
			end
			default: begin
				state_d = itsu_pkg::ST_IDLE;
			end
		endcase
	end

`include "index_to_sequence_unranker_assert.svh"

	`ITSU_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && sts.last, state_q == itsu_pkg::ST_IDLE, "no idle after final beat")

endmodule

// ===== rtl/index_to_sequence_unranker.sv =====
// channel | handshake           | payload
// in      | in_valid / in_stall   | index[31:0]
// out     | out_valid / out_stall | element[16:0], last, empty_res
//
// Each element runs setup, 9 root rounds (two root bits per
// round in the shared square-root datapath), one check, finish, one output beat.
// An index gives up to 7 beats; index zero skips the root rounds and gives one empty beat.
// One index is in flight at a time; in_stall is high until the final beat leaves.
// out_stall holds the current beat and freezes the sequencer.
// arst_n clears the sequencer and counters; no clearing pass.
module index_to_sequence_unranker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [itsu_pkg::IDX_IN_W-1:0] index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [itsu_pkg::ELEM_W-1:0]   element,
	output logic                          last,
	output logic                          empty_res
);

	itsu_pkg::cmd_t cmd;
	itsu_pkg::sts_t sts;

	itsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	itsu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.index     (index),
		.element   (element),
		.last      (last),
		.empty_res (empty_res)
	);

endmodule

// ===== test/index_to_sequence_unranker_test.sv =====
`timescale 1ns / 1ps

module index_to_sequence_unranker_test;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 300;

	typedef struct packed {
		logic [itsu_pkg::ELEM_W-1:0] element;
		logic                        last;
		logic                        empty_res;
	} seq_beat_t;

	class unrank_scoreboard;
		seq_beat_t expected_q[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function bit [33:0] tri_root(bit [63:0] n);
			bit [33:0] k;
			bit [33:0] cand;
			bit [71:0] c72;
			k = '0;
			for (int b = 33; b >= 0; b--) begin
				cand = k | (34'd1 << b);
				c72 = 72'(cand);
				if (((c72 * (c72 + 72'd1)) >> 1) <= n)
					k = cand;
			end
			return k;
		endfunction

		function void note_index(logic [itsu_pkg::IDX_IN_W-1:0] v);
			bit [63:0] head;
			bit [63:0] n;
			bit [71:0] k72;
			bit [71:0] rest;
			seq_beat_t beat;
			int        count;
			head = 64'(v) & ((64'd1 << itsu_pkg::INDEX_WIDTH) - 64'd1);
			if (head == 0) begin
				beat.element = '0;
				beat.last = 1'b1;
				beat.empty_res = 1'b1;
				expected_q.push_back(beat);
				return;
			end
			count = 0;
			while (head != 0 && count < itsu_pkg::MAX_RESULTS) begin
				n = head - 64'd1;
				k72 = 72'(tri_root(n));
				rest = 72'(n) - ((k72 * (k72 + 72'd1)) >> 1);
				head = (rest <= k72) ? 64'(k72 - rest) : 64'd0;
				beat.element = rest[itsu_pkg::ELEM_W-1:0];
				beat.empty_res = 1'b0;
				count++;
				beat.last = (head == 0 || count == itsu_pkg::MAX_RESULTS);
				expected_q.push_back(beat);
			end
		endfunction

		function void check_beat(logic [itsu_pkg::ELEM_W-1:0] e, logic l, logic em);
			seq_beat_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: element=%0d last=%b empty_res=%b", e, l, em);
				return;
			end
			want = expected_q.pop_front();
			if (want.element !== e || want.last !== l || want.empty_res !== em) begin
				errors++;
				if (errors <= 10)
					$display("beat mismatch: expected element=%0d last=%b empty_res=%b, got element=%0d last=%b empty_res=%b",
						want.element, want.last, want.empty_res, e, l, em);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [itsu_pkg::IDX_IN_W-1:0] index = '0;
	logic                          out_valid;
	logic                          out_stall;
	logic [itsu_pkg::ELEM_W-1:0]   element;
	logic                          last;
	logic                          empty_res;

	unrank_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	int idle_cycles = 0;

	index_to_sequence_unranker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.index     (index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.element   (element),
		.last      (last),
		.empty_res (empty_res)
	);

	always #5 clk = ~clk;

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_stall === 1'b0)
			sb.check_beat(element, last, empty_res);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_index(logic [itsu_pkg::IDX_IN_W-1:0] v);
		if (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		index <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_index(v);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [itsu_pkg::IDX_IN_W-1:0] random_index();
		int pick;
		int w;
		pick = $urandom_range(0, 99);
		w = $urandom_range(1, itsu_pkg::IDX_IN_W);
		if (pick < 45)
			return $urandom();
		else if (pick < 65)
			return $urandom_range(0, 1000);
		else if (pick < 72)
			return $urandom_range(0, 3);
		else
			return itsu_pkg::IDX_IN_W'($urandom() & ((64'd1 << w) - 64'd1));
	endfunction

	logic [itsu_pkg::IDX_IN_W-1:0] directed [0:19] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd10, 32'd100,
		32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
		32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000, 32'd0, 32'h1234_5678
	};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_index(directed[i]);

		quiet = 1'b1;
		repeat (40) send_index(random_index());
		quiet = 1'b0;

		hold_go = 1'b1;
		repeat (6) send_index(random_index());

		drain_results();
		repeat ($urandom_range(1, 5)) @(posedge clk);

		repeat (RANDOM_ITEMS - 46) send_index(random_index());

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
